FILE: rtl/core/mtt_pkg.sv
// ---------------------------------------------------------------------------
// mtt_pkg: shared types and constants of the markup tag tokeniser
// Character codes, parser phases, event codes and the records passed
// between the stages of the tokeniser.
// ---------------------------------------------------------------------------
package mtt_pkg;

  localparam int unsigned MAX_LINE_DEF  = 1024;
  localparam int unsigned MAX_ATTRS_DEF = 16;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [3:0] {
    PH_WAIT_LT     = 4'd0,
    PH_AFTER_LT    = 4'd1,
    PH_NAME        = 4'd2,
    PH_CLOSE_SKIP  = 4'd3,
    PH_GAP         = 4'd4,
    PH_ATTR_NAME   = 4'd5,
    PH_AFTER_NAME  = 4'd6,
    PH_VALUE_START = 4'd7,
    PH_QUOTED      = 4'd8,
    PH_SLASH_VALUE = 4'd9,
    PH_PLAIN_VALUE = 4'd10,
    PH_SLASH_PEND  = 4'd11,
    PH_STOPPED     = 4'd12,
    PH_NAME_FIRST  = 4'd13
  } phase_t;

  typedef enum logic [2:0] {
    EV_NAME  = 3'd0,
    EV_ANAME = 3'd1,
    EV_VALUE = 3'd2,
    EV_DONE  = 3'd3,
    EV_NO_LT = 3'd4,
    EV_BAD   = 3'd5,
    EV_LONG  = 3'd6,
    EV_MANY  = 3'd7
  } event_t;

  // One character request held in the input stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
    logic       first;
  } stage_t;

  // One result request from the parser core.
  typedef struct packed {
    logic       valid;
    event_t     event_res;
    logic [7:0] char_out;
    logic       closing;
    logic [3:0] attr_index;
    logic       last;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

endpackage

FILE: rtl/core/mtt_in_if.sv
// ---------------------------------------------------------------------------
// mtt_in_if: character channel
// Valid/ready channel carrying one tag character and its start-of-tag flag.
// ---------------------------------------------------------------------------
interface mtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       first;

  modport source (output valid, output char_code, output first, input ready);
  modport sink   (input valid, input char_code, input first, output ready);
endinterface

FILE: rtl/core/mtt_out_if.sv
// ---------------------------------------------------------------------------
// mtt_out_if: token event channel
// Valid/ready channel carrying one token event of the tokeniser.
// ---------------------------------------------------------------------------
interface mtt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] char_out;
  logic       closing;
  logic [3:0] attr_index;
  logic       last;

  modport source (output valid, output event_res, output char_out, output closing,
                  output attr_index, output last, input ready);
  modport sink   (input valid, input event_res, input char_out, input closing,
                  input attr_index, input last, output ready);
endinterface

FILE: rtl/core/markup_tag_tokenizer.sv
// A token event passes from the input register through the core into the result register.
// Throughput: one character per cycle, set by the parser state registers, as
// long as the result side takes each event when it is offered.
// Characters that produce no event still pass through the core.
// Reset (rst_n low at a clock edge) empties both stages and puts the parser back to
// waiting for the start of a tag.
// ---------------------------------------------------------------------------
// markup_tag_tokenizer: streaming tokeniser for a single markup tag
// Takes one character per request and emits tag name, attribute name and
// attribute value characters, then done or an error code.
// ---------------------------------------------------------------------------
module markup_tag_tokenizer #(
  parameter int unsigned MAX_LINE  = mtt_pkg::MAX_LINE_DEF,
  parameter int unsigned MAX_ATTRS = mtt_pkg::MAX_ATTRS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mtt_in_if.sink    in_chan,
  mtt_out_if.source out_chan
);

  // The design is a three-part pipeline. The input stage registers each
  // character request. The core holds the parser state (phase, closing flag,
  // attribute count and the saturating character position) and decides in a
  // single pass of logic what the registered character produces. The output
  // stage registers the resulting event and lets the input side keep flowing
  // while that event is taken.

  mtt_pkg::stage_t stage;
  mtt_pkg::res_t   res;
  logic            slot_free;

  // The core consumes the held character only when the result register can
  // take whatever event it produces, so no event is ever dropped.
  mtt_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (slot_free),
    .stage   (stage)
  );

  mtt_core #(
    .MAX_LINE  (MAX_LINE),
    .MAX_ATTRS (MAX_ATTRS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (slot_free),
    .res     (res)
  );

  mtt_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

endmodule

FILE: rtl/core/mtt_in_stage.sv
// ---------------------------------------------------------------------------
// mtt_in_stage: input register
// Captures one character request and holds it until the core consumes it.
// ---------------------------------------------------------------------------
module mtt_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  mtt_in_if.sink          in_chan,
  input  logic            advance,
  output mtt_pkg::stage_t stage
);

  logic       valid_r, valid_nxt;
  logic [7:0] char_r;
  logic       first_r;
  logic       take;

  // The register can refill in the cycle its content moves on.
  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_chan.ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_r  <= in_chan.char_code;
      first_r <= in_chan.first;
    end
  end

  assign stage.valid     = valid_r;
  assign stage.char_code = char_r;
  assign stage.first     = first_r;

endmodule

FILE: rtl/core/mtt_core.sv
// ---------------------------------------------------------------------------
// mtt_core: tokeniser state machine
// Holds the parser state and decides, for one character, the event it
// produces and the state it leaves behind.
// ---------------------------------------------------------------------------
module mtt_core #(
  parameter int unsigned MAX_LINE  = mtt_pkg::MAX_LINE_DEF,
  parameter int unsigned MAX_ATTRS = mtt_pkg::MAX_ATTRS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mtt_pkg::stage_t stage,
  input  logic            advance,
  output mtt_pkg::res_t   res
);

  localparam int unsigned PW = $clog2(MAX_LINE);
  localparam int unsigned AW = $clog2(MAX_ATTRS + 1);
  localparam logic [PW-1:0] LONG_POS  = PW'(MAX_LINE - 2);
  localparam logic [AW-1:0] ATTR_LIM  = AW'(MAX_ATTRS);

  mtt_pkg::phase_t phase_r, phase_nxt;
  logic            closing_r, closing_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;

  mtt_pkg::phase_t eff_phase;
  logic            eff_closing;
  logic [AW-1:0]   eff_cnt;
  logic [PW-1:0]   eff_pos;
  logic [AW-1:0]   cur;
  logic            step;
  logic            live;
  logic [7:0]      c;

  logic            emit;
  mtt_pkg::event_t ev;
  logic [AW-1:0]   ix;
  logic [AW+3:0]   ix_wide;

  assign step = stage.valid && advance;
  assign c    = stage.char_code;

  // A request flagged as first starts from the reset state.
  assign eff_phase   = stage.first ? mtt_pkg::PH_WAIT_LT : phase_r;
  assign eff_closing = stage.first ? 1'b0 : closing_r;
  assign eff_cnt     = stage.first ? '0 : cnt_r;
  assign eff_pos     = stage.first ? '0 : pos_r;
  assign cur         = (eff_cnt != '0) ? eff_cnt - AW'(1) : '0;
  assign live        = step && (eff_phase != mtt_pkg::PH_STOPPED);

  // Event decision.
  always_comb begin
    emit = 1'b0;
    ev   = mtt_pkg::EV_NAME;
    ix   = '0;
    if (live) begin
      if (eff_pos == LONG_POS) begin
        emit = 1'b1;
        ev   = mtt_pkg::EV_LONG;
      end else begin
        unique case (eff_phase)
          mtt_pkg::PH_WAIT_LT: begin
            if (c != mtt_pkg::CH_SPACE && c != mtt_pkg::CH_LT) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_NO_LT;
            end
          end
          mtt_pkg::PH_AFTER_LT, mtt_pkg::PH_NAME_FIRST, mtt_pkg::PH_NAME: begin
            priority if (eff_phase == mtt_pkg::PH_AFTER_LT && c == mtt_pkg::CH_SLASH) begin
              emit = 1'b0;
            end else if (c == mtt_pkg::CH_GT) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_DONE;
            end else if (eff_phase == mtt_pkg::PH_NAME && c == mtt_pkg::CH_SPACE) begin
              emit = 1'b0;
            end else if (!mtt_pkg::is_letter(c)) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_BAD;
            end else begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_NAME;
            end
          end
          mtt_pkg::PH_CLOSE_SKIP, mtt_pkg::PH_SLASH_PEND: begin
            if (c == mtt_pkg::CH_GT) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_DONE;
            end else if (eff_phase == mtt_pkg::PH_SLASH_PEND) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_BAD;
            end
          end
          mtt_pkg::PH_GAP, mtt_pkg::PH_AFTER_NAME: begin
            priority if (c == mtt_pkg::CH_SPACE || c == mtt_pkg::CH_SLASH) begin
              emit = 1'b0;
            end else if (eff_phase == mtt_pkg::PH_AFTER_NAME && c == mtt_pkg::CH_EQ) begin
              emit = 1'b0;
            end else if (c == mtt_pkg::CH_GT) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_DONE;
            end else if (!mtt_pkg::is_letter(c)) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_BAD;
            end else if (eff_cnt >= ATTR_LIM) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_MANY;
            end else begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_ANAME;
              ix   = eff_cnt;
            end
          end
          mtt_pkg::PH_ATTR_NAME: begin
            priority if (c == mtt_pkg::CH_GT) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_DONE;
            end else if (c == mtt_pkg::CH_SPACE || c == mtt_pkg::CH_EQ) begin
              emit = 1'b0;
            end else if (!mtt_pkg::is_letter(c)) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_BAD;
            end else begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_ANAME;
              ix   = cur;
            end
          end
          mtt_pkg::PH_VALUE_START: begin
            priority if (c == mtt_pkg::CH_SPACE || c == mtt_pkg::CH_QUOTE) begin
              emit = 1'b0;
            end else if (c == mtt_pkg::CH_GT) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_DONE;
            end else begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_VALUE;
              ix   = cur;
            end
          end
          mtt_pkg::PH_QUOTED: begin
            if (c != mtt_pkg::CH_QUOTE) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_VALUE;
              ix   = cur;
            end
          end
          mtt_pkg::PH_SLASH_VALUE, mtt_pkg::PH_PLAIN_VALUE: begin
            priority if (c == mtt_pkg::CH_SPACE) begin
              emit = 1'b0;
            end else if (eff_phase == mtt_pkg::PH_PLAIN_VALUE && c == mtt_pkg::CH_GT) begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_DONE;
            end else begin
              emit = 1'b1;
              ev   = mtt_pkg::EV_VALUE;
              ix   = cur;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  // Next state.
  always_comb begin
    phase_nxt   = phase_r;
    closing_nxt = closing_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    if (step) begin
      phase_nxt   = eff_phase;
      closing_nxt = eff_closing;
      cnt_nxt     = eff_cnt;
      pos_nxt     = eff_pos;
    end
    if (live) begin
      // The position counter saturates so that it never wraps back.
      if (eff_pos != '1) begin
        pos_nxt = eff_pos + PW'(1);
      end
      if (emit && ev >= mtt_pkg::EV_DONE) begin
        phase_nxt = mtt_pkg::PH_STOPPED;
      end else begin
        unique case (eff_phase)
          mtt_pkg::PH_WAIT_LT: begin
            if (c == mtt_pkg::CH_LT) begin
              phase_nxt = mtt_pkg::PH_AFTER_LT;
            end
          end
          mtt_pkg::PH_AFTER_LT: begin
            if (c == mtt_pkg::CH_SLASH) begin
              closing_nxt = 1'b1;
              phase_nxt   = mtt_pkg::PH_NAME_FIRST;
            end else if (emit) begin
              phase_nxt = mtt_pkg::PH_NAME;
            end
          end
          mtt_pkg::PH_NAME_FIRST: begin
            if (emit) begin
              phase_nxt = mtt_pkg::PH_NAME;
            end
          end
          mtt_pkg::PH_NAME: begin
            if (c == mtt_pkg::CH_SPACE) begin
              phase_nxt = eff_closing ? mtt_pkg::PH_CLOSE_SKIP : mtt_pkg::PH_GAP;
            end
          end
          mtt_pkg::PH_GAP, mtt_pkg::PH_AFTER_NAME: begin
            if (c == mtt_pkg::CH_SLASH) begin
              phase_nxt = mtt_pkg::PH_SLASH_PEND;
            end else if (eff_phase == mtt_pkg::PH_AFTER_NAME && c == mtt_pkg::CH_EQ) begin
              phase_nxt = mtt_pkg::PH_VALUE_START;
            end else if (emit && ev == mtt_pkg::EV_ANAME) begin
              cnt_nxt   = eff_cnt + AW'(1);
              phase_nxt = mtt_pkg::PH_ATTR_NAME;
            end
          end
          mtt_pkg::PH_ATTR_NAME: begin
            if (c == mtt_pkg::CH_SPACE) begin
              phase_nxt = mtt_pkg::PH_AFTER_NAME;
            end else if (c == mtt_pkg::CH_EQ) begin
              phase_nxt = mtt_pkg::PH_VALUE_START;
            end
          end
          mtt_pkg::PH_VALUE_START: begin
            if (c == mtt_pkg::CH_QUOTE) begin
              phase_nxt = mtt_pkg::PH_QUOTED;
            end else if (emit) begin
              phase_nxt = (c == mtt_pkg::CH_SLASH) ? mtt_pkg::PH_SLASH_VALUE
                                                    : mtt_pkg::PH_PLAIN_VALUE;
            end
          end
          mtt_pkg::PH_QUOTED: begin
            if (c == mtt_pkg::CH_QUOTE) begin
              phase_nxt = mtt_pkg::PH_GAP;
            end
          end
          mtt_pkg::PH_SLASH_VALUE, mtt_pkg::PH_PLAIN_VALUE: begin
            if (c == mtt_pkg::CH_SPACE) begin
              phase_nxt = mtt_pkg::PH_GAP;
            end
          end
          mtt_pkg::PH_CLOSE_SKIP, mtt_pkg::PH_SLASH_PEND, mtt_pkg::PH_STOPPED: begin
            phase_nxt = eff_phase;
          end
          default: begin
            phase_nxt = mtt_pkg::PH_STOPPED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= mtt_pkg::PH_WAIT_LT;
      closing_r <= 1'b0;
      cnt_r     <= '0;
      pos_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      closing_r <= closing_nxt;
      cnt_r     <= cnt_nxt;
      pos_r     <= pos_nxt;
    end
  end

  assign ix_wide = {4'b0000, ix};

  always_comb begin
    res.valid      = emit;
    res.event_res  = ev;
    res.char_out   = (ev <= mtt_pkg::EV_VALUE) ? c : 8'h00;
    res.closing    = eff_closing;
    res.attr_index = (ev == mtt_pkg::EV_ANAME || ev == mtt_pkg::EV_VALUE) ? ix_wide[3:0]
                                                                          : 4'h0;
    res.last       = (ev >= mtt_pkg::EV_DONE);
  end

endmodule

FILE: rtl/core/mtt_out_stage.sv
// ---------------------------------------------------------------------------
// mtt_out_stage: result register
// Holds one token event until the downstream side takes it.
// ---------------------------------------------------------------------------
module mtt_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  mtt_pkg::res_t res,
  output logic          slot_free,
  mtt_out_if.source     out_chan
);

  logic          valid_r, valid_nxt;
  mtt_pkg::res_t res_r;

  assign slot_free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.event_res  = res_r.event_res;
  assign out_chan.char_out   = res_r.char_out;
  assign out_chan.closing    = res_r.closing;
  assign out_chan.attr_index = res_r.attr_index;
  assign out_chan.last       = res_r.last;

endmodule
